// File: design/sgr_pkg.sv
// Shared types and constants for the stream group reverser.
// Used by sgr_ctrl, sgr_dpath and stream_group_reverser; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sgr_pkg;

	localparam int MAX_GROUP_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 16;

	// group_size register
	localparam int          CFG_WIDTH = 5;
	localparam logic [4:0]  CFG_RESET = 5'd1;

	typedef enum logic [0:0] {
		ST_FILL  = 1'b0,
		ST_DRAIN = 1'b1
	} sgr_state_t;

	// controller -> datapath
	typedef struct packed {
		logic grow;   // buffer one more value
		logic start;  // accepted value closes the group, begin readout
		logic issue;  // issue one buffer read toward the output
	} sgr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic complete;    // fill + incoming value reaches the group size
		logic s1_free;     // read stage can take a new read this cycle
		logic final_read;  // current read is the last of the group
	} sgr_status_t;

endpackage
`default_nettype wire

// File: design/stream_group_reverser.sv
// Top level of the stream group reverser: controller plus datapath.
// Depends on sgr_pkg, sgr_ctrl and sgr_dpath.
`timescale 1ns / 1ps
`default_nettype none
// Reverses a stream of list values in groups of group_size. Values are taken
// one per cycle into a group buffer. When the buffer plus the incoming value
// reaches the group size, the group leaves in reverse order; when the value
// flagged by s_tlast closes an incomplete group, that group leaves in arrival
// order. The final output of a list carries m_tlast. group_size 0 acts as 1,
// values above MAX_GROUP act as MAX_GROUP; lowering it mid-group flushes the
// whole held group reversed once it is reached. A value that closes a group
// stops input while the controller issues one buffer read per cycle (one
// read port on the group buffer), stalling when the read stage cannot take a
// new read; results then stream at one per cycle through a read stage and an
// output register, stalling under m_tready. Input reopens as soon as the last
// read is issued, so gathering the next group overlaps the tail of the readout.
// The user must write group_size only while the block is idle; the block
// itself does not enforce this.
module stream_group_reverser #(
	parameter int MAX_GROUP  = sgr_pkg::MAX_GROUP_DEF,
	parameter int DATA_WIDTH = sgr_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 group_size_wen,
	input  wire logic [sgr_pkg::CFG_WIDTH-1:0]        group_size,
	// input stream
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]      s_tdata,  // value
	input  wire logic                                 s_tlast,  // end_of_list
	// output stream
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]           m_tdata,  // out_value
	output logic                                      m_tlast   // out_last
);
	import sgr_pkg::*;

	localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;

	sgr_cmd_t              cmd;
	sgr_status_t           status;
	logic [DATA_WIDTH-1:0] out_value;

	// controller: gather / readout sequencing and input request flow
	sgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: buffer, counters, read stage and output register
	sgr_dpath #(
		.MAX_GROUP  (MAX_GROUP),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.group_size_wen (group_size_wen),
		.group_size     (group_size),
		.in_value       (s_tdata[DATA_WIDTH-1:0]),
		.in_last        (s_tlast),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_value      (out_value),
		.out_last       (m_tlast)
	);

	// pad the result value with zeros up to whole bytes
	assign m_tdata = TDW'(out_value);

endmodule
`default_nettype wire

// File: design/sgr_ctrl.sv
// Controller FSM: gathers values, then sequences the buffer readout.
// Depends on sgr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tlast,
	output logic                      s_tready,
	input  wire sgr_pkg::sgr_status_t status,
	output sgr_pkg::sgr_cmd_t         cmd
);
	import sgr_pkg::*;

	sgr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		cmd.grow  = 1'b0;
		cmd.start = 1'b0;
		cmd.issue = 1'b0;
		case (state_q)
			ST_FILL: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (status.complete || s_tlast) begin
						cmd.start = 1'b1;
						state_d   = ST_DRAIN;
					end else begin
						cmd.grow = 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				cmd.issue = status.s1_free;
				if (status.s1_free && status.final_read) begin
					state_d = ST_FILL;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/sgr_dpath.sv
// Datapath: group buffer memory, fill/readout counters, read stage, output register.
// Depends on sgr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgr_dpath #(
	parameter int MAX_GROUP  = sgr_pkg::MAX_GROUP_DEF,
	parameter int DATA_WIDTH = sgr_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          group_size_wen,
	input  wire logic [sgr_pkg::CFG_WIDTH-1:0] group_size,
	input  wire logic [DATA_WIDTH-1:0]         in_value,
	input  wire logic                          in_last,
	input  wire sgr_pkg::sgr_cmd_t             cmd,
	output sgr_pkg::sgr_status_t               status,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [DATA_WIDTH-1:0]              out_value,
	output logic                               out_last
);
	import sgr_pkg::*;

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int SW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

	logic [DATA_WIDTH-1:0] mem [MAX_GROUP];

	logic [CFG_WIDTH-1:0]  size_cfg_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         total_q;
	logic [CW-1:0]         idx_q;
	logic                  rev_q;
	logic                  eol_q;

	logic                  rd_valid_s1;
	logic [DATA_WIDTH-1:0] rd_value_s1;
	logic                  rd_last_s1;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	logic                  out_last_q;

	logic [SW-1:0]         size_eff;
	logic [CW-1:0]         n_next;
	logic [CW-1:0]         rd_ptr;
	logic                  out_free;

	// group size clamp: 0 acts as 1, above MAX_GROUP acts as MAX_GROUP
	always_comb begin
		if (size_cfg_q == '0) begin
			size_eff = SW'(1);
		end else if (SW'(size_cfg_q) > SW'(MAX_GROUP)) begin
			size_eff = SW'(MAX_GROUP);
		end else begin
			size_eff = SW'(size_cfg_q);
		end
	end

	assign n_next   = fill_q + CW'(1);
	assign rd_ptr   = rev_q ? (total_q - CW'(1) - idx_q) : idx_q;
	assign out_free = !out_valid_q || out_ready;

	assign status.complete   = SW'(n_next) >= size_eff;
	assign status.s1_free    = !rd_valid_s1 || out_free;
	assign status.final_read = (idx_q == total_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q <= CFG_RESET;
		end else if (group_size_wen) begin
			size_cfg_q <= group_size;
		end
	end

	// fill and readout counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			idx_q   <= '0;
			rev_q   <= 1'b0;
			eol_q   <= 1'b0;
		end else begin
			if (cmd.grow) begin
				fill_q <= n_next;
			end else if (cmd.start) begin
				fill_q  <= '0;
				total_q <= n_next;
				idx_q   <= '0;
				rev_q   <= status.complete;
				eol_q   <= in_last;
			end else if (cmd.issue) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// group buffer: write on accept, registered read on issue
	always_ff @(posedge clk) begin
		if (cmd.grow || cmd.start) begin
			mem[fill_q[AW-1:0]] <= in_value;
		end
		if (cmd.issue) begin
			rd_value_s1 <= mem[rd_ptr[AW-1:0]];
			rd_last_s1  <= status.final_read && eol_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (cmd.issue) begin
			rd_valid_s1 <= 1'b1;
		end else if (out_free) begin
			rd_valid_s1 <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= rd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && rd_valid_s1) begin
			out_value_q <= rd_value_s1;
			out_last_q  <= rd_last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire
